// ===== rtl/core/cwg_pkg.sv =====
// Shared types and constants for the coverage waypoint generator.
// No dependencies; every other file in rtl/core imports this package.
package cwg_pkg;

    localparam int GRID_DIM    = 256;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [5:0] SCALE_RESET = 6'd1;

    typedef enum logic [2:0] {
        HD_NONE  = 3'd0,
        HD_WEST  = 3'd1,
        HD_EAST  = 3'd2,
        HD_SOUTH = 3'd3,
        HD_NORTH = 3'd4
    } heading_t;

    // bit 2: incoming cell (else previous cell), bit 1: row high offset,
    // bit 0: column high offset
    typedef enum logic [2:0] {
        PT_CUR_LL = 3'b000,
        PT_CUR_LH = 3'b001,
        PT_CUR_HL = 3'b010,
        PT_CUR_HH = 3'b011,
        PT_NXT_LL = 3'b100,
        PT_NXT_LH = 3'b101,
        PT_NXT_HL = 3'b110,
        PT_NXT_HH = 3'b111
    } pt_code_t;

    typedef struct packed {
        logic [7:0] cell_row;
        logic [7:0] cell_col;
        logic       tour_start;
    } cell_item_t;

    typedef struct packed {
        logic [15:0] waypoint_row;
        logic [15:0] waypoint_col;
        logic        last_of_run;
    } waypoint_item_t;

    // One move to be expanded into waypoints by the back end
    typedef struct packed {
        logic [7:0]     prev_row;
        logic [7:0]     prev_col;
        logic [7:0]     row;
        logic [7:0]     col;
        logic [1:0]     last_idx;
        pt_code_t [3:0] pts;
    } move_job_t;

endpackage

// ===== rtl/core/cwg_front.sv =====
// Front end: takes tour cells, tracks previous cell and heading, and
// turns each adjacent move into a job with its waypoint list. Uses cwg_pkg.
module cwg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cwg_pkg::cell_item_t cell_item,
    input  logic                queue_full,
    output logic                full,
    output logic                job_push,
    output cwg_pkg::move_job_t  job
);
    import cwg_pkg::*;

    logic [7:0] prev_row_reg;
    logic [7:0] prev_col_reg;
    logic       prev_valid_reg;
    heading_t   heading_reg;
    heading_t   heading_next;

    logic     accept;
    logic     in_grid;
    logic     first;
    heading_t dir;

    assign full   = queue_full;
    assign accept = push && !queue_full;

    always_comb
    begin
        in_grid = ({1'b0, cell_item.cell_row} < 9'(GRID_DIM))
               && ({1'b0, cell_item.cell_col} < 9'(GRID_DIM));
        first   = cell_item.tour_start || !prev_valid_reg;

        dir = HD_NONE;
        if (cell_item.cell_row == prev_row_reg
            && {1'b0, cell_item.cell_col} == {1'b0, prev_col_reg} + 9'd1)
            dir = HD_EAST;
        else if (cell_item.cell_row == prev_row_reg
            && {1'b0, cell_item.cell_col} + 9'd1 == {1'b0, prev_col_reg})
            dir = HD_WEST;
        else if (cell_item.cell_col == prev_col_reg
            && {1'b0, cell_item.cell_row} + 9'd1 == {1'b0, prev_row_reg})
            dir = HD_NORTH;
        else if (cell_item.cell_col == prev_col_reg
            && {1'b0, cell_item.cell_row} == {1'b0, prev_row_reg} + 9'd1)
            dir = HD_SOUTH;

        job.prev_row = prev_row_reg;
        job.prev_col = prev_col_reg;
        job.row      = cell_item.cell_row;
        job.col      = cell_item.cell_col;
        job.last_idx = 2'd0;
        job.pts[0]   = PT_CUR_LL;
        job.pts[1]   = PT_CUR_LL;
        job.pts[2]   = PT_CUR_LL;
        job.pts[3]   = PT_CUR_LL;

        // corner points on the previous cell first, then the edge point
        unique case (dir)
            HD_EAST:
            begin
                if (heading_reg == HD_SOUTH)
                begin
                    job.pts[0] = PT_CUR_HL; job.pts[1] = PT_CUR_HH;
                    job.pts[2] = PT_NXT_HL; job.last_idx = 2'd2;
                end
                else if (heading_reg == HD_WEST)
                begin
                    job.pts[0] = PT_CUR_LL; job.pts[1] = PT_CUR_HL;
                    job.pts[2] = PT_CUR_HH; job.pts[3] = PT_NXT_HL;
                    job.last_idx = 2'd3;
                end
                else
                    job.pts[0] = PT_NXT_HL;
            end
            HD_WEST:
            begin
                if (heading_reg == HD_NORTH)
                begin
                    job.pts[0] = PT_CUR_LH; job.pts[1] = PT_CUR_LL;
                    job.pts[2] = PT_NXT_LH; job.last_idx = 2'd2;
                end
                else if (heading_reg == HD_EAST)
                begin
                    job.pts[0] = PT_CUR_HH; job.pts[1] = PT_CUR_LH;
                    job.pts[2] = PT_CUR_LL; job.pts[3] = PT_NXT_LH;
                    job.last_idx = 2'd3;
                end
                else
                    job.pts[0] = PT_NXT_LH;
            end
            HD_NORTH:
            begin
                if (heading_reg == HD_EAST)
                begin
                    job.pts[0] = PT_CUR_HH; job.pts[1] = PT_CUR_LH;
                    job.pts[2] = PT_NXT_HH; job.last_idx = 2'd2;
                end
                else if (heading_reg == HD_SOUTH)
                begin
                    job.pts[0] = PT_CUR_HL; job.pts[1] = PT_CUR_HH;
                    job.pts[2] = PT_CUR_LH; job.pts[3] = PT_NXT_HH;
                    job.last_idx = 2'd3;
                end
                else
                    job.pts[0] = PT_NXT_HH;
            end
            HD_SOUTH:
            begin
                if (heading_reg == HD_WEST)
                begin
                    job.pts[0] = PT_CUR_LL; job.pts[1] = PT_CUR_HL;
                    job.pts[2] = PT_NXT_LL; job.last_idx = 2'd2;
                end
                else if (heading_reg == HD_NORTH)
                begin
                    job.pts[0] = PT_CUR_LH; job.pts[1] = PT_CUR_LL;
                    job.pts[2] = PT_CUR_HL; job.pts[3] = PT_NXT_LL;
                    job.last_idx = 2'd3;
                end
                else
                    job.pts[0] = PT_NXT_LL;
            end
            default:
            begin
                job.pts[0] = PT_CUR_LL;
            end
        endcase

        job_push = accept && in_grid && !first && (dir != HD_NONE);

        if (first)
            heading_next = HD_NONE;
        else if (dir != HD_NONE)
            heading_next = dir;
        else
            heading_next = heading_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_row_reg   <= '0;
            prev_col_reg   <= '0;
            prev_valid_reg <= 1'b0;
            heading_reg    <= HD_NONE;
        end
        else if (accept && in_grid)
        begin
            prev_row_reg   <= cell_item.cell_row;
            prev_col_reg   <= cell_item.cell_col;
            prev_valid_reg <= 1'b1;
            heading_reg    <= heading_next;
        end
    end

endmodule

// ===== rtl/core/cwg_queue.sv =====
// Short job queue between front and back end.
// Register-array FIFO of cwg_pkg::move_job_t, depth QUEUE_DEPTH.
module cwg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  cwg_pkg::move_job_t wr_data,
    output logic               full,
    input  logic               rd_en,
    output cwg_pkg::move_job_t rd_data,
    output logic               empty
);
    import cwg_pkg::*;

    move_job_t             mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/core/cwg_back.sv =====
// Back end: expands a move job into fine-grid waypoints, one per cycle while the
// output register is free, through a one-entry output register. Uses cwg_pkg.
module cwg_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [5:0]              scale,
    input  logic                    job_empty,
    input  cwg_pkg::move_job_t      job,
    output logic                    job_pop,
    output logic                    empty,
    input  logic                    pop,
    output cwg_pkg::waypoint_item_t waypoint
);
    import cwg_pkg::*;

    logic [15:0] cr_hi_reg, cr_lo_reg, cc_hi_reg, cc_lo_reg;
    logic [15:0] nr_hi_reg, nr_lo_reg, nc_hi_reg, nc_lo_reg;
    pt_code_t [3:0] pts_reg;
    logic [1:0]  last_idx_reg;
    logic [1:0]  idx_reg;
    logic        busy_reg;
    waypoint_item_t out_reg;
    logic        out_valid_reg;

    logic        slot_free;
    logic        emit;
    logic        emit_last;
    pt_code_t    code;
    logic [15:0] sel_row;
    logic [15:0] sel_col;
    logic [5:0]  half_dn;
    logic [6:0]  half_up;

    function automatic logic [15:0] centre_of(input logic [7:0] i, input logic [5:0] s);
        logic [14:0] prod;
        prod = {i, 1'b1} * s;
        return {1'b0, prod};
    endfunction

    assign half_dn = {1'b0, scale[5:1]};
    assign half_up = ({1'b0, scale} + 7'd1) >> 1;

    function automatic logic [15:0] hi_of(input logic [15:0] c, input logic [5:0] h);
        return c + {10'd0, h};
    endfunction

    function automatic logic [15:0] lo_of(input logic [15:0] c, input logic [6:0] h);
        return c - {9'd0, h};
    endfunction

    always_comb
    begin
        slot_free = !out_valid_reg || pop;
        emit      = busy_reg && slot_free;
        emit_last = emit && (idx_reg == last_idx_reg);
        job_pop   = !job_empty && (!busy_reg || emit_last);

        code    = pts_reg[idx_reg];
        if (code[2])
        begin
            sel_row = code[1] ? nr_hi_reg : nr_lo_reg;
            sel_col = code[0] ? nc_hi_reg : nc_lo_reg;
        end
        else
        begin
            sel_row = code[1] ? cr_hi_reg : cr_lo_reg;
            sel_col = code[0] ? cc_hi_reg : cc_lo_reg;
        end
    end

    assign empty    = !out_valid_reg;
    assign waypoint = out_reg;

    // offsets of both cells, computed once when a job is taken
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cr_hi_reg    <= hi_of(centre_of(job.prev_row, scale), half_dn);
            cr_lo_reg    <= lo_of(centre_of(job.prev_row, scale), half_up);
            cc_hi_reg    <= hi_of(centre_of(job.prev_col, scale), half_dn);
            cc_lo_reg    <= lo_of(centre_of(job.prev_col, scale), half_up);
            nr_hi_reg    <= hi_of(centre_of(job.row, scale), half_dn);
            nr_lo_reg    <= lo_of(centre_of(job.row, scale), half_up);
            nc_hi_reg    <= hi_of(centre_of(job.col, scale), half_dn);
            nc_lo_reg    <= lo_of(centre_of(job.col, scale), half_up);
            pts_reg      <= job.pts;
            last_idx_reg <= job.last_idx;
        end
        if (emit)
        begin
            out_reg.waypoint_row <= sel_row;
            out_reg.waypoint_col <= sel_col;
            out_reg.last_of_run  <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (emit_last)
                busy_reg <= 1'b0;
            else if (emit)
                idx_reg <= idx_reg + 1'b1;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> busy_reg && (idx_reg == 2'd0))
        else $error("job load did not restart the waypoint index");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= last_idx_reg))
        else $error("waypoint index ran past the job's last point");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_last && !job_pop) |=> !busy_reg && !empty && waypoint.last_of_run)
        else $error("final waypoint of a run not flagged or sequencer stayed busy");

    a_no_lost_output: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (empty || pop))
        else $error("waypoint emitted over an unread result");

endmodule

// ===== rtl/core/coverage_waypoint_generator.sv =====
// Coverage waypoint generator: takes tour cells through a push/full queue port and
// delivers fine-grid waypoints through an empty/pop port, plus a robot_scale write port.
// Uses cwg_pkg, cwg_front, cwg_queue, cwg_back.
//
// A cell is accepted every cycle while full is low; a first cell, a non-adjacent
// cell or a repeat produces no waypoints, an adjacent move produces one to four.
// Waypoints leave at one per cycle while the receiver keeps popping, a rate set by
// the single output register of the back end; a four-entry job queue lets the
// cell side keep going while waypoints drain. The first waypoint of a move passes
// through the job queue, the back end's job registers and its output register.
// robot_scale resets to 1 and may be written only while the block is idle.
module coverage_waypoint_generator (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  cwg_pkg::cell_item_t     cell_item,
    output logic                    empty,
    input  logic                    pop,
    output cwg_pkg::waypoint_item_t waypoint,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [5:0]              cfg_data
);
    import cwg_pkg::*;

    logic       [5:0] robot_scale_reg;
    logic             queue_full;
    logic             queue_empty;
    logic             job_push;
    logic             job_pop;
    move_job_t        job_in;
    move_job_t        job_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            robot_scale_reg <= SCALE_RESET;
        else if (cfg_valid && cfg_ready)
            robot_scale_reg <= cfg_data;
    end

    cwg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .cell_item  (cell_item),
        .queue_full (queue_full),
        .full       (full),
        .job_push   (job_push),
        .job        (job_in)
    );

    cwg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (queue_full),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .empty   (queue_empty)
    );

    cwg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .scale     (robot_scale_reg),
        .job_empty (queue_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .waypoint  (waypoint)
    );

endmodule

// ===== verif/coverage_waypoint_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the coverage waypoint generator: watches the cell, waypoint and
// scale write channels, predicts the waypoints of each accepted cell and compares.
// Depends on cwg_pkg for the payload types and heading codes.
module coverage_waypoint_checker
    import cwg_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic           full,
    input  cell_item_t     cell_item,
    input  logic           pop,
    input  logic           empty,
    input  waypoint_item_t waypoint,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [5:0]     cfg_data,
    output int             fail_count,
    output int             due_count
);

    logic [5:0]     scale;
    logic [7:0]     last_row;
    logic [7:0]     last_col;
    logic           have_last;
    heading_t       dir;
    int             n_fail;
    waypoint_item_t waypoints_due[$];

    function automatic logic [15:0] centre(input logic [7:0] idx);
        return 16'((2 * int'(idx) + 1) * int'(scale));
    endfunction

    function automatic logic [15:0] hi_off(input logic [15:0] c);
        return c + 16'(int'(scale) >> 1);
    endfunction

    function automatic logic [15:0] lo_off(input logic [15:0] c);
        return c - 16'((int'(scale) + 1) >> 1);
    endfunction

    function automatic waypoint_item_t wp(input logic [15:0] row, input logic [15:0] col);
        waypoint_item_t w;
        w.waypoint_row = row;
        w.waypoint_col = col;
        w.last_of_run  = 1'b0;
        return w;
    endfunction

    // Expands one accepted cell into the waypoints of its move, updates the tour state
    task automatic predict_waypoints(input cell_item_t c);
        waypoint_item_t run[$];
        logic [15:0]    hr, lr, hc, lc, nr, nc;
        int             row, col, prow, pcol;
        row  = int'(c.cell_row);
        col  = int'(c.cell_col);
        prow = int'(last_row);
        pcol = int'(last_col);
        if (c.tour_start || !have_last)
        begin
            last_row  = c.cell_row;
            last_col  = c.cell_col;
            have_last = 1'b1;
            dir       = HD_NONE;
            return;
        end
        hr = hi_off(centre(last_row));
        lr = lo_off(centre(last_row));
        hc = hi_off(centre(last_col));
        lc = lo_off(centre(last_col));
        nr = centre(c.cell_row);
        nc = centre(c.cell_col);
        if (row == prow && col == pcol + 1)
        begin
            if (dir == HD_SOUTH)
            begin
                run = {run, wp(hr, lc)};
                run = {run, wp(hr, hc)};
            end
            else if (dir == HD_WEST)
            begin
                run = {run, wp(lr, lc)};
                run = {run, wp(hr, lc)};
                run = {run, wp(hr, hc)};
            end
            run = {run, wp(hi_off(nr), lo_off(nc))};
            dir = HD_EAST;
        end
        else if (row == prow && col + 1 == pcol)
        begin
            if (dir == HD_NORTH)
            begin
                run = {run, wp(lr, hc)};
                run = {run, wp(lr, lc)};
            end
            else if (dir == HD_EAST)
            begin
                run = {run, wp(hr, hc)};
                run = {run, wp(lr, hc)};
                run = {run, wp(lr, lc)};
            end
            run = {run, wp(lo_off(nr), hi_off(nc))};
            dir = HD_WEST;
        end
        else if (col == pcol && row + 1 == prow)
        begin
            if (dir == HD_EAST)
            begin
                run = {run, wp(hr, hc)};
                run = {run, wp(lr, hc)};
            end
            else if (dir == HD_SOUTH)
            begin
                run = {run, wp(hr, lc)};
                run = {run, wp(hr, hc)};
                run = {run, wp(lr, hc)};
            end
            run = {run, wp(hi_off(nr), hi_off(nc))};
            dir = HD_NORTH;
        end
        else if (col == pcol && row == prow + 1)
        begin
            if (dir == HD_WEST)
            begin
                run = {run, wp(lr, lc)};
                run = {run, wp(hr, lc)};
            end
            else if (dir == HD_NORTH)
            begin
                run = {run, wp(lr, hc)};
                run = {run, wp(lr, lc)};
                run = {run, wp(hr, lc)};
            end
            run = {run, wp(lo_off(nr), lo_off(nc))};
            dir = HD_SOUTH;
        end
        // non-adjacent or repeated cell: no waypoints, heading kept
        last_row = c.cell_row;
        last_col = c.cell_col;
        if (run.size() != 0)
        begin
            run[run.size() - 1].last_of_run = 1'b1;
        end
        foreach (run[i])
        begin
            waypoints_due = {waypoints_due, run[i]};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        waypoint_item_t want;
        if (!rst_n)
        begin
            scale      = SCALE_RESET;
            last_row   = '0;
            last_col   = '0;
            have_last  = 1'b0;
            dir        = HD_NONE;
            n_fail     = 0;
            waypoints_due.delete();
            fail_count <= 0;
            due_count  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                scale = cfg_data;
            end
            // check results before predicting: a cell accepted now cannot match a pop now
            if (pop && !empty)
            begin
                if (waypoints_due.size() == 0)
                begin
                    $error("unexpected waypoint: row %0d col %0d last %0b",
                           waypoint.waypoint_row, waypoint.waypoint_col, waypoint.last_of_run);
                    n_fail++;
                end
                else
                begin
                    want = waypoints_due.pop_front();
                    if (waypoint.waypoint_row !== want.waypoint_row)
                    begin
                        $error("waypoint_row: expected %0d, actual %0d",
                               want.waypoint_row, waypoint.waypoint_row);
                        n_fail++;
                    end
                    if (waypoint.waypoint_col !== want.waypoint_col)
                    begin
                        $error("waypoint_col: expected %0d, actual %0d",
                               want.waypoint_col, waypoint.waypoint_col);
                        n_fail++;
                    end
                    if (waypoint.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last_of_run, waypoint.last_of_run);
                        n_fail++;
                    end
                end
            end
            if (push && !full)
            begin
                predict_waypoints(cell_item);
            end
            fail_count <= n_fail;
            due_count  <= waypoints_due.size();
        end
    end

endmodule

// ===== verif/tb_coverage_waypoint_generator.sv =====
`timescale 1ns / 1ps
// Top of the coverage waypoint generator testbench: clock, reset, cell stimulus,
// result stalls, scale writes and the verdict. Needs cwg_pkg, the block and
// coverage_waypoint_checker.
module tb_coverage_waypoint_generator;
    import cwg_pkg::*;

    localparam int PHASES          = 5;
    localparam int CELLS_PER_PHASE = 29;
    localparam int SETTLE_CYCLES   = 10;
    localparam int STUCK_LIMIT     = 2000;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           push      = 1'b0;
    logic           pop       = 1'b0;
    logic           cfg_valid = 1'b0;
    logic [5:0]     cfg_data  = '0;
    cell_item_t     cell_item = '0;
    logic           full;
    logic           empty;
    logic           cfg_ready;
    waypoint_item_t waypoint;
    int             fail_count;
    int             due_count;

    int             burst_left   = 0;
    int             walk_row     = 0;
    int             walk_col     = 0;
    int             stall_left   = 0;
    int             rx_cycle     = 0;
    int             stuck_cycles = 0;

    always #5 clk = ~clk;

    coverage_waypoint_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cell_item (cell_item),
        .empty     (empty),
        .pop       (pop),
        .waypoint  (waypoint),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    coverage_waypoint_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cell_item  (cell_item),
        .pop        (pop),
        .empty      (empty),
        .waypoint   (waypoint),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    function automatic cell_item_t tour_cell(input int row, input int col, input bit start);
        cell_item_t c;
        c.cell_row   = 8'(row);
        c.cell_col   = 8'(col);
        c.tour_start = start;
        return c;
    endfunction

    // Sender works in bursts; a gap may open before each burst
    task automatic push_cell(input cell_item_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push      <= 1'b1;
        cell_item <= c;
        do @(posedge clk); while (full);
    endtask

    // Holds off until every predicted waypoint has been popped and the pipe is quiet
    task automatic settle();
        push <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (due_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_scale(input logic [5:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a random walk over 4-neighbours; some new tours, jumps and repeats
    task automatic walk_cell();
        int         pick;
        bit         start;
        cell_item_t c;
        pick  = $urandom_range(0, 99);
        start = 1'b0;
        if (pick < 6)
        begin
            start = 1'b1;
            if ($urandom_range(0, 2) == 0)
            begin
                walk_row = $urandom_range(0, 1) * 255;
                walk_col = $urandom_range(0, 1) * 255;
            end
            else
            begin
                walk_row = $urandom_range(0, 255);
                walk_col = $urandom_range(0, 255);
            end
        end
        else if (pick < 10)
        begin
            walk_row = $urandom_range(0, 255);
            walk_col = $urandom_range(0, 255);
        end
        else if (pick >= 13)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    walk_row = (walk_row == 255) ? 254 : walk_row + 1;
                else
                    walk_row = (walk_row == 0) ? 1 : walk_row - 1;
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    walk_col = (walk_col == 255) ? 254 : walk_col + 1;
                else
                    walk_col = (walk_col == 0) ? 1 : walk_col - 1;
            end
        end
        c = tour_cell(walk_row, walk_col, start);
        push_cell(c);
    endtask

    // Receiver: stall pattern changes with bits 7:6 of the receive cycle counter
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop        <= 1'b0;
            stall_left <= 0;
            rx_cycle   <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (stall_left != 0)
            begin
                pop        <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                case (rx_cycle[7:6])
                    2'd0: pop <= 1'b1;
                    2'd1: pop <= 1'($urandom_range(0, 1));
                    2'd2:
                    begin
                        if ($urandom_range(0, 19) == 0)
                        begin
                            pop        <= 1'b0;
                            stall_left <= $urandom_range(3, 15);
                        end
                        else
                        begin
                            pop <= 1'b1;
                        end
                    end
                    default: pop <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Watchdog: any transfer on any channel counts as progress
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        logic [5:0] phase_scale;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk at the reset scale; first cell has no tour_start
        push_cell(tour_cell(0, 0, 0));
        push_cell(tour_cell(0, 1, 0));      // east, no heading yet
        push_cell(tour_cell(1, 1, 0));      // south after east
        push_cell(tour_cell(1, 0, 0));      // west after south
        push_cell(tour_cell(0, 0, 0));      // north after west
        push_cell(tour_cell(0, 1, 0));      // east after north
        push_cell(tour_cell(1, 1, 0));      // south after east
        push_cell(tour_cell(1, 2, 0));      // east corner after south
        push_cell(tour_cell(0, 2, 0));      // north corner after east
        push_cell(tour_cell(0, 1, 0));      // west corner after north
        push_cell(tour_cell(1, 1, 0));      // south corner after west
        push_cell(tour_cell(1, 0, 0));      // west after south
        push_cell(tour_cell(1, 1, 0));      // U-turn east after west
        push_cell(tour_cell(1, 0, 0));      // U-turn west after east
        push_cell(tour_cell(0, 0, 0));      // north after west
        push_cell(tour_cell(1, 0, 0));      // U-turn south after north
        push_cell(tour_cell(0, 0, 0));      // U-turn north after south
        push_cell(tour_cell(0, 0, 0));      // repeat: nothing, heading kept
        push_cell(tour_cell(5, 5, 0));      // jump: nothing
        push_cell(tour_cell(255, 255, 1));  // new tour at the far corner
        push_cell(tour_cell(255, 254, 0));
        push_cell(tour_cell(254, 254, 0));
        push_cell(tour_cell(254, 255, 0));
        push_cell(tour_cell(255, 255, 0));
        push_cell(tour_cell(0, 255, 0));    // jump across the grid
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       phase_scale = 6'd63;
                1:       phase_scale = 6'd0;
                2:       phase_scale = 6'($urandom_range(2, 62));
                3:       phase_scale = 6'($urandom_range(1, 63));
                default: phase_scale = 6'd1;
            endcase
            write_scale(phase_scale);
            repeat (CELLS_PER_PHASE) walk_cell();
            settle();
        end

        if (fail_count == 0 && due_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cwg_pkg.sv
rtl/core/cwg_front.sv
rtl/core/cwg_queue.sv
rtl/core/cwg_back.sv
rtl/core/coverage_waypoint_generator.sv
verif/coverage_waypoint_checker.sv
verif/tb_coverage_waypoint_generator.sv
